### hw/rtl/energy_time_centroid_simpson_defines.svh
// ----------------------------------------------------------------------------
// Energy time centroid: assertion macros
// Shared helpers for the port checker.
// ----------------------------------------------------------------------------
`ifndef ENERGY_TIME_CENTROID_SIMPSON_DEFINES_SVH
`define ENERGY_TIME_CENTROID_SIMPSON_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define ETC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define ETC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, always live (for reset behaviour).
`define ETC_ASSERT_NEXT_LIVE(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/etc_pkg.sv
// ----------------------------------------------------------------------------
// Energy time centroid package
// Widths, payload types and limits shared by all modules.
// ----------------------------------------------------------------------------
package etc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = SAMPLE_W + 1;   // |-32768| = 2^15; one bit wider than a sample
    localparam int SQR_W     = 31;             // square of a magnitude, <= 2^30
    localparam int EN_W      = 32;             // re^2 + im^2, <= 2^31
    localparam int WEN_W     = EN_W + 2;       // times weight of up to 4
    localparam int IDX_W     = 12;
    localparam int TERM_W    = WEN_W + IDX_W;  // 46
    localparam int ESUM_W    = 46;
    localparam int MSUM_W    = 58;
    localparam int FRAC_BITS = 8;
    localparam int CENT_W    = 20;
    localparam int INT_W     = CENT_W - FRAC_BITS;
    localparam int TOTAL_W   = 24;
    localparam int CNT_W     = 5;
    localparam int STEP_W    = 5;

    localparam logic [IDX_W-1:0] MAX_INDEX    = IDX_W'(4095);
    localparam logic [CNT_W-1:0] MAX_CHANNELS = CNT_W'(16);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_real;
        logic signed [SAMPLE_W-1:0] sample_imag;
        logic                       end_of_channel;
    } sample_t;

    typedef struct packed {
        logic [CENT_W-1:0] centroid_index;
        logic              zero_energy_seen;
        logic              length_overflow;
    } result_t;

    // One finished channel: both sums and its length flag.
    typedef struct packed {
        logic [MSUM_W-1:0] moment_sum;
        logic [ESUM_W-1:0] energy_sum;
        logic              overflow;
    } chan_sums_t;

endpackage

### hw/rtl/etc_front.sv
// ----------------------------------------------------------------------------
// Energy time centroid: front end
// Weights and accumulates samples; hands finished channel sums on.
// ----------------------------------------------------------------------------
module etc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  etc_pkg::sample_t    sample,
    output logic                chan_push,
    output etc_pkg::chan_sums_t chan_sums,
    input  logic                chan_full
);
    import etc_pkg::*;

    typedef enum logic [1:0] {
        WT_ONE  = 2'd0,
        WT_TWO  = 2'd1,
        WT_FOUR = 2'd2
    } weight_t;

    function automatic logic [MAG_W-1:0] magnitude(input logic signed [SAMPLE_W-1:0] v);
        logic [MAG_W-1:0] ext;
        ext = MAG_W'(v);
        return v[SAMPLE_W-1] ? (~ext + 1'b1) : ext;
    endfunction

    logic                advance;
    logic                take;
    logic [MAG_W-1:0]    mag_re;
    logic [MAG_W-1:0]    mag_im;
    logic [2*MAG_W-1:0]  prod_re;
    logic [2*MAG_W-1:0]  prod_im;
    weight_t             weight;

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                ovf_reg, ovf_next;

    logic                s1_valid_reg;
    logic [SQR_W-1:0]    s1_sq_re_reg;
    logic [SQR_W-1:0]    s1_sq_im_reg;
    weight_t             s1_weight_reg;
    logic [IDX_W-1:0]    s1_idx_reg;
    logic                s1_last_reg;
    logic                s1_ovf_reg;

    logic [EN_W-1:0]     energy;
    logic [WEN_W-1:0]    wen;
    logic [TERM_W-1:0]   term;

    logic                s2_valid_reg;
    logic [WEN_W-1:0]    s2_wen_reg;
    logic [TERM_W-1:0]   s2_term_reg;
    logic                s2_last_reg;
    logic                s2_ovf_reg;

    logic [ESUM_W-1:0]   esum_reg;
    logic [MSUM_W-1:0]   msum_reg;
    logic [ESUM_W:0]     esum_wide;
    logic [MSUM_W:0]     msum_wide;
    logic [ESUM_W-1:0]   esum_add;
    logic [MSUM_W-1:0]   msum_add;

    // Whole pipe holds while a channel end waits for queue space.
    assign advance = !(s2_valid_reg && s2_last_reg && chan_full);
    assign full    = !advance;
    assign take    = push && advance;

    assign mag_re  = magnitude(sample.sample_real);
    assign mag_im  = magnitude(sample.sample_imag);
    assign prod_re = mag_re * mag_re;
    assign prod_im = mag_im * mag_im;

    always_comb
    begin
        if (idx_reg == '0 || sample.end_of_channel)
        begin
            weight = WT_ONE;
        end
        else if (idx_reg[0])
        begin
            weight = WT_FOUR;
        end
        else
        begin
            weight = WT_TWO;
        end
    end

    // Index saturates at the last legal value and flags the channel.
    always_comb
    begin
        idx_next = idx_reg;
        ovf_next = ovf_reg;
        if (take)
        begin
            if (sample.end_of_channel)
            begin
                idx_next = '0;
                ovf_next = 1'b0;
            end
            else if (idx_reg == MAX_INDEX)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        energy = {1'b0, s1_sq_re_reg} + {1'b0, s1_sq_im_reg};
        case (s1_weight_reg)
            WT_ONE:  wen = WEN_W'(energy);
            WT_TWO:  wen = {1'b0, energy, 1'b0};
            WT_FOUR: wen = {energy, 2'b00};
            default: wen = WEN_W'(energy);
        endcase
    end

    assign term = wen * s1_idx_reg;

    // Saturating accumulation
    always_comb
    begin
        esum_wide = {1'b0, esum_reg} + (ESUM_W+1)'(s2_wen_reg);
        msum_wide = {1'b0, msum_reg} + (MSUM_W+1)'(s2_term_reg);
        esum_add  = esum_wide[ESUM_W] ? '1 : esum_wide[ESUM_W-1:0];
        msum_add  = msum_wide[MSUM_W] ? '1 : msum_wide[MSUM_W-1:0];
    end

    assign chan_push            = s2_valid_reg && s2_last_reg && !chan_full;
    assign chan_sums.moment_sum = msum_add;
    assign chan_sums.energy_sum = esum_add;
    assign chan_sums.overflow   = s2_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            ovf_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            esum_reg     <= '0;
            msum_reg     <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            ovf_reg <= ovf_next;
            if (advance)
            begin
                s1_valid_reg <= take;
                s2_valid_reg <= s1_valid_reg;
                if (s2_valid_reg)
                begin
                    if (s2_last_reg)
                    begin
                        esum_reg <= '0;
                        msum_reg <= '0;
                    end
                    else
                    begin
                        esum_reg <= esum_add;
                        msum_reg <= msum_add;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_sq_re_reg  <= prod_re[SQR_W-1:0];
            s1_sq_im_reg  <= prod_im[SQR_W-1:0];
            s1_weight_reg <= weight;
            s1_idx_reg    <= idx_reg;
            s1_last_reg   <= sample.end_of_channel;
            s1_ovf_reg    <= ovf_reg;
        end
        if (advance && s1_valid_reg)
        begin
            s2_wen_reg  <= wen;
            s2_term_reg <= term;
            s2_last_reg <= s1_last_reg;
            s2_ovf_reg  <= s1_ovf_reg;
        end
    end

endmodule

### hw/rtl/etc_chq.sv
// ----------------------------------------------------------------------------
// Energy time centroid: channel queue
// Two-entry queue of finished channel sums between front and back.
// ----------------------------------------------------------------------------
module etc_chq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  etc_pkg::chan_sums_t wr_data,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output etc_pkg::chan_sums_t rd_data
);
    import etc_pkg::*;

    chan_sums_t slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic [1:0] wr_pos;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign rd_data = slot_reg[0];

    // Head shifts down on pop, so the write lands one place lower.
    assign wr_pos     = count_reg - {1'b0, pop};
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // A write to the head wins over the shift from the second slot.
    always_ff @(posedge clk)
    begin
        if (push && wr_pos == 2'd0)
        begin
            slot_reg[0] <= wr_data;
        end
        else if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
        end
        if (push && wr_pos == 2'd1)
        begin
            slot_reg[1] <= wr_data;
        end
    end

endmodule

### hw/rtl/etc_back.sv
// ----------------------------------------------------------------------------
// Energy time centroid: back end
// Serial centroid divide, group averaging and the result register.
// ----------------------------------------------------------------------------
module etc_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    chan_empty,
    output logic                    chan_pop,
    input  etc_pkg::chan_sums_t     chan_sums,
    input  logic [etc_pkg::CNT_W-1:0] channel_count,
    output logic                    res_empty,
    input  logic                    res_pop,
    output etc_pkg::result_t        result
);
    import etc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CDIV = 5'b00010,
        ST_ACC  = 5'b00100,
        ST_ADIV = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [ESUM_W-1:0]   rem_reg,   rem_next;
    logic [ESUM_W-1:0]   dvs_reg,   dvs_next;
    logic [CENT_W-1:0]   quo_reg,   quo_next;
    logic [STEP_W-1:0]   step_reg,  step_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]    done_reg,  done_next;
    logic                zero_reg,  zero_next;
    logic                ovf_reg,   ovf_next;
    logic                rzero_reg, rzero_next;
    logic                rovf_reg,  rovf_next;
    logic [TOTAL_W-1:0]  avg_reg,   avg_next;
    logic [CNT_W-1:0]    arem_reg,  arem_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_data_reg,  out_data_next;

    logic [CNT_W-1:0]    eff;
    logic [ESUM_W+1:0]   cdiff;
    logic                cge;
    logic [CNT_W+1:0]    adiff;
    logic                age;
    logic [TOTAL_W-1:0]  total_sum;
    logic [CNT_W-1:0]    done_inc;
    logic                slot_free;

    always_comb
    begin
        if (channel_count == '0)
        begin
            eff = CNT_W'(1);
        end
        else if (channel_count > MAX_CHANNELS)
        begin
            eff = MAX_CHANNELS;
        end
        else
        begin
            eff = channel_count;
        end
    end

    // One restoring step each for the centroid and the average divides.
    assign cdiff = {1'b0, rem_reg, quo_reg[CENT_W-1]} - {2'b00, dvs_reg};
    assign cge   = !cdiff[ESUM_W+1];
    assign adiff = {1'b0, arem_reg, avg_reg[TOTAL_W-1]} - {2'b00, eff};
    assign age   = !adiff[CNT_W+1];

    assign total_sum = total_reg + TOTAL_W'(quo_reg);
    assign done_inc  = done_reg + 1'b1;
    assign slot_free = !out_valid_reg || res_pop;

    assign chan_pop  = (state_reg == ST_IDLE) && !chan_empty;
    assign res_empty = !out_valid_reg;
    assign result    = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        total_next     = total_reg;
        done_next      = done_reg;
        zero_next      = zero_reg;
        ovf_next       = ovf_reg;
        rzero_next     = rzero_reg;
        rovf_next      = rovf_reg;
        avg_next       = avg_reg;
        arem_next      = arem_reg;
        out_valid_next = out_valid_reg && !res_pop;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!chan_empty)
                begin
                    dvs_next  = chan_sums.energy_sum;
                    ovf_next  = ovf_reg | chan_sums.overflow;
                    step_next = '0;
                    if (chan_sums.energy_sum == '0)
                    begin
                        // silent channel counts as centroid zero
                        zero_next  = 1'b1;
                        quo_next   = '0;
                        state_next = ST_ACC;
                    end
                    else if (chan_sums.moment_sum >= {chan_sums.energy_sum, {INT_W{1'b0}}})
                    begin
                        quo_next   = '1;
                        state_next = ST_ACC;
                    end
                    else
                    begin
                        rem_next   = chan_sums.moment_sum[MSUM_W-1:INT_W];
                        quo_next   = {chan_sums.moment_sum[INT_W-1:0], {FRAC_BITS{1'b0}}};
                        state_next = ST_CDIV;
                    end
                end
            end

            ST_CDIV:
            begin
                rem_next  = cge ? cdiff[ESUM_W-1:0] : {rem_reg[ESUM_W-2:0], quo_reg[CENT_W-1]};
                quo_next  = {quo_reg[CENT_W-2:0], cge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CENT_W - 1))
                begin
                    state_next = ST_ACC;
                end
            end

            ST_ACC:
            begin
                if (done_inc >= eff)
                begin
                    avg_next   = total_sum;
                    arem_next  = '0;
                    step_next  = '0;
                    rzero_next = zero_reg;
                    rovf_next  = ovf_reg;
                    total_next = '0;
                    done_next  = '0;
                    zero_next  = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = ST_ADIV;
                end
                else
                begin
                    total_next = total_sum;
                    done_next  = done_inc;
                    state_next = ST_IDLE;
                end
            end

            ST_ADIV:
            begin
                arem_next = age ? adiff[CNT_W-1:0] : {arem_reg[CNT_W-2:0], avg_reg[TOTAL_W-1]};
                avg_next  = {avg_reg[TOTAL_W-2:0], age};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(TOTAL_W - 1))
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.centroid_index   = avg_reg[CENT_W-1:0];
                    out_data_next.zero_energy_seen = rzero_reg;
                    out_data_next.length_overflow  = rovf_reg;
                    state_next                    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            total_reg     <= '0;
            done_reg      <= '0;
            zero_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            total_reg     <= total_next;
            done_reg      <= done_next;
            zero_reg      <= zero_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        quo_reg      <= quo_next;
        rzero_reg    <= rzero_next;
        rovf_reg     <= rovf_next;
        avg_reg      <= avg_next;
        arem_reg     <= arem_next;
        out_data_reg <= out_data_next;
    end

endmodule

### hw/rtl/energy_time_centroid_simpson.sv
// ----------------------------------------------------------------------------
// Energy time centroid (Simpson weighted), top level
// Per-channel energy centroid of complex samples, averaged over a group.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ---------------------------------------
//  input     push / full               sample   (real, imag, end of channel)
//  result    empty / pop               result   (centroid, zero, overflow)
//  config    cfg_valid / cfg_ready     cfg_data (channel count, 5 bits)
//
//  Samples: one transfer per cycle while full is low; a sample passes the s1
//  and s2 registers into the sums. Each channel end takes the back end through
//  a pop, 20 centroid bits and an add, the bits skipped for a silent or
//  saturated channel; a group end adds 24 average bits and the output load.
//  The two-entry channel queue absorbs short channels; full rises only while
//  the queue is full and a channel end waits behind it. A result left waiting
//  holds the back end; intake goes on until the queue fills. rst_n clears all
//  control state and sets the channel count to 1; cfg_ready is always high.
//
module energy_time_centroid_simpson (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  etc_pkg::sample_t          sample,
    output logic                      empty,
    input  logic                      pop,
    output etc_pkg::result_t          result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [etc_pkg::CNT_W-1:0] cfg_data
);
    import etc_pkg::*;

    logic              chq_push;
    logic              chq_full;
    logic              chq_pop;
    logic              chq_empty;
    chan_sums_t        chq_wr_data;
    chan_sums_t        chq_rd_data;
    logic [CNT_W-1:0]  count_reg;

    // Configuration register: one transfer per cycle, never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    // Front: magnitudes, squares, Simpson weight, saturating sums.
    etc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .chan_push (chq_push),
        .chan_sums (chq_wr_data),
        .chan_full (chq_full)
    );

    // Decouples sample intake from the serial divides.
    etc_chq u_chq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (chq_push),
        .wr_data (chq_wr_data),
        .full    (chq_full),
        .pop     (chq_pop),
        .empty   (chq_empty),
        .rd_data (chq_rd_data)
    );

    // Back: centroid divide, group total, average divide, result register.
    etc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .chan_empty    (chq_empty),
        .chan_pop      (chq_pop),
        .chan_sums     (chq_rd_data),
        .channel_count (count_reg),
        .res_empty     (empty),
        .res_pop       (pop),
        .result        (result)
    );

endmodule

### hw/rtl/etc_checker.sv
// ----------------------------------------------------------------------------
// Energy time centroid: port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "energy_time_centroid_simpson_defines.svh"

module etc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input etc_pkg::result_t result,
    input logic             cfg_ready
);
    import etc_pkg::*;

    `ETC_ASSERT_NEXT_LIVE(a_reset_state, clk, !rst_n, !full && empty, "reset left full or a result")
    `ETC_ASSERT_NEXT(a_result_held, clk, rst_n, !empty && !pop, !empty, "result dropped unread")
    `ETC_ASSERT_NEXT(a_result_stable, clk, rst_n, !empty && !pop, $stable(result), "result changed")
    `ETC_ASSERT_IMPLY(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready, "config port stalled")

endmodule

bind energy_time_centroid_simpson etc_checker u_etc_checker (.*);
